// ===== hdl/cmap4_pkg.sv =====
// Shared types and constants for the cmap format-4 glyph lookup block.
// No dependencies; the channel interfaces, cmap4_walk and the top level import this package.
`default_nettype none

package cmap4_pkg;

  localparam int unsigned TB_W     = 14;  // table_bytes register width
  localparam int unsigned IDX_W    = 13;  // byte_index width
  localparam int unsigned CP_W     = 21;  // codepoint width
  localparam int unsigned GLYPH_W  = 16;
  localparam int unsigned ADDR_W   = 20;  // internal byte address width
  localparam int unsigned TB_MAX   = (2 ** TB_W) - 1;

  localparam logic [ADDR_W-1:0] OFF_LEN     = 20'd2;   // length field
  localparam logic [ADDR_W-1:0] OFF_X2      = 20'd6;   // segCountX2 field
  localparam logic [ADDR_W-1:0] HDR_BYTES   = 20'd14;  // start of endCode array
  localparam logic [ADDR_W-1:0] ARR_FIXED   = 20'd16;  // header plus reserved pad
  localparam logic [15:0]       LEN_MIN     = 16'd24;
  localparam logic [TB_W-1:0]   BOUND_MIN   = 14'd16;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FMT  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_X2,
    S_CHK,
    S_END,
    S_START,
    S_DELTA,
    S_RANGE,
    S_PCALC,
    S_PCHK,
    S_FETCH,
    S_DONE
  } walk_state_e;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    status_e            status;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/cmap4_in_if.sv =====
// Input channel of the glyph lookup block: table byte writes and lookups.
// Depends on cmap4_pkg for field widths.
`default_nettype none

interface cmap4_in_if import cmap4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [IDX_W-1:0]  byte_index;
  logic [7:0]        byte_value;
  logic [CP_W-1:0]   codepoint;

  modport source (output valid, opcode, byte_index, byte_value, codepoint, input ready);
  modport sink   (input valid, opcode, byte_index, byte_value, codepoint, output ready);
endinterface

`default_nettype wire

// ===== hdl/cmap4_out_if.sv =====
// Result channel of the glyph lookup block: glyph index and status.
// Depends on cmap4_pkg for field widths.
`default_nettype none

interface cmap4_out_if import cmap4_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [GLYPH_W-1:0] glyph_index;
  logic [1:0]         status;

  modport source (output valid, glyph_index, status, input ready);
  modport sink   (input valid, glyph_index, status, output ready);
endinterface

`default_nettype wire

// ===== hdl/cmap4_mem.sv =====
// Byte-wide subtable memory: one write port, one read port, registered read data.
// No package dependencies.
`default_nettype none

module cmap4_mem #(
  parameter int unsigned DEPTH  = 8192,
  parameter int unsigned ADDR_BITS = 13
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic [7:0]           wdata_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic      [7:0]           rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/cmap4_walk.sv =====
// Lookup sequencer: header checks, segment walk and glyph fetch over the byte memory.
// Depends on cmap4_pkg; drives the read port of cmap4_mem.
`default_nettype none

module cmap4_walk import cmap4_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 8192,
  parameter int unsigned ADDR_BITS   = 13
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [TB_W-1:0]      table_bytes_i,
  input  wire logic                 start_i,
  input  wire logic [CP_W-1:0]      cp_i,
  output logic                      idle_o,
  output logic      [ADDR_BITS-1:0] raddr_o,
  input  wire logic [7:0]           rdata_i,
  output logic                      res_valid_o,
  output res_t                      res_o,
  input  wire logic                 res_ready_i
);

  localparam int unsigned BoundCap = (TABLE_DEPTH < TB_MAX) ? TABLE_DEPTH : TB_MAX;

  walk_state_e state_q, state_d;
  logic [1:0]  ph_q, ph_d;

  logic [CP_W-1:0]   cp_q, cp_d;
  logic [7:0]        hi_q, hi_d;
  logic [15:0]       len_q, len_d;
  logic [15:0]       seg2_q, seg2_d;
  logic [14:0]       i_q, i_d;
  logic [ADDR_W-1:0] ea_q, ea_d;
  logic [ADDR_W-1:0] s_off_q, s_off_d;
  logic [ADDR_W-1:0] d_off_q, d_off_d;
  logic [ADDR_W-1:0] r_off_q, r_off_d;
  logic [15:0]       d_q, d_d;
  logic [15:0]       diff_q, diff_d;
  logic [ADDR_W-1:0] p_q, p_d;
  res_t              res_q, res_d;

  logic [TB_W-1:0]   lim;
  logic [ADDR_W-1:0] lim_w;
  logic [15:0]       word;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] rd_addr;
  logic              word_rdy;
  logic [ADDR_W-1:0] seg2_w;

  assign lim   = (table_bytes_i > TB_W'(BoundCap)) ? TB_W'(BoundCap) : table_bytes_i;
  assign lim_w = ADDR_W'(lim);
  assign word  = {hi_q, rdata_i};
  assign seg2_w = ADDR_W'(seg2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q    <= cp_d;
    hi_q    <= hi_d;
    len_q   <= len_d;
    seg2_q  <= seg2_d;
    i_q     <= i_d;
    ea_q    <= ea_d;
    s_off_q <= s_off_d;
    d_off_q <= d_off_d;
    r_off_q <= r_off_d;
    d_q     <= d_d;
    diff_q  <= diff_d;
    p_q     <= p_d;
    res_q   <= res_d;
  end

  // Each 16-bit word is read in phases: issue the high byte address, issue the
  // low byte address while catching the high byte, then use the whole word.
  always_comb begin
    case (state_q)
      S_LEN:   base = OFF_LEN;
      S_X2:    base = OFF_X2;
      S_END:   base = ea_q;
      S_START: base = ea_q + s_off_q;
      S_DELTA: base = ea_q + d_off_q;
      S_RANGE: base = ea_q + r_off_q;
      S_FETCH: base = p_q;
      default: base = '0;
    endcase
    rd_addr = base + ADDR_W'(ph_q == 2'd1);
  end

  assign raddr_o = rd_addr[ADDR_BITS-1:0];

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    cp_d    = cp_q;
    hi_d    = hi_q;
    len_d   = len_q;
    seg2_d  = seg2_q;
    i_d     = i_q;
    ea_d    = ea_q;
    s_off_d = s_off_q;
    d_off_d = d_off_q;
    r_off_d = r_off_q;
    d_d     = d_q;
    diff_d  = diff_q;
    p_d     = p_q;
    res_d   = res_q;
    idle_o      = 1'b0;
    res_valid_o = 1'b0;

    word_rdy = (ph_q == 2'd2);
    if (ph_q == 2'd1) begin
      hi_d = rdata_i;
    end

    case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        ph_d   = 2'd0;
        if (start_i) begin
          cp_d = cp_i;
          if (lim < BOUND_MIN) begin
            res_d   = '{glyph: '0, status: ST_FMT};
            state_d = S_DONE;
          end else begin
            state_d = S_LEN;
          end
        end
      end

      S_LEN, S_X2, S_END, S_START, S_DELTA, S_RANGE, S_FETCH: begin
        ph_d = word_rdy ? 2'd0 : ph_q + 2'd1;
        if (state_q == S_END && ph_q == 2'd0 && i_q == seg2_q[15:1]) begin
          // Every segment has been tried.
          res_d   = '{glyph: '0, status: ST_MISS};
          state_d = S_DONE;
          ph_d    = 2'd0;
        end else if (word_rdy) begin
          case (state_q)
            S_LEN: begin
              len_d = word;
              if (word > 16'(lim) || word < LEN_MIN) begin
                res_d   = '{glyph: '0, status: ST_FMT};
                state_d = S_DONE;
              end else begin
                state_d = S_X2;
              end
            end
            S_X2: begin
              seg2_d = {word[15:1], 1'b0};
              if (word == 16'd0 ||
                  (HDR_BYTES + ADDR_W'({word, 1'b0})) > ADDR_W'(len_q)) begin
                res_d   = '{glyph: '0, status: ST_FMT};
                state_d = S_DONE;
              end else begin
                state_d = S_CHK;
              end
            end
            S_END: begin
              if (cp_q > CP_W'(word)) begin
                i_d  = i_q + 15'd1;
                ea_d = ea_q + 20'd2;
              end else begin
                state_d = S_START;
              end
            end
            S_START: begin
              diff_d = cp_q[15:0] - word;
              if (cp_q < CP_W'(word)) begin
                i_d     = i_q + 15'd1;
                ea_d    = ea_q + 20'd2;
                state_d = S_END;
              end else begin
                state_d = S_DELTA;
              end
            end
            S_DELTA: begin
              d_d     = word;
              state_d = S_RANGE;
            end
            S_RANGE: begin
              if (word == 16'd0) begin
                res_d   = '{glyph: cp_q[15:0] + d_q, status: ST_OK};
                state_d = S_DONE;
              end else begin
                p_d     = ea_q + r_off_q + ADDR_W'(word);
                state_d = S_PCALC;
              end
            end
            S_FETCH: begin
              res_d   = '{glyph: (word == 16'd0) ? 16'd0 : word + d_q, status: ST_OK};
              state_d = S_DONE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_CHK: begin
        if (ARR_FIXED + {seg2_w[ADDR_W-3:0], 2'b00} > lim_w) begin
          res_d   = '{glyph: '0, status: ST_FMT};
          state_d = S_DONE;
        end else begin
          s_off_d = seg2_w + 20'd2;
          d_off_d = {seg2_w[ADDR_W-2:0], 1'b0} + 20'd2;
          r_off_d = seg2_w + {seg2_w[ADDR_W-2:0], 1'b0} + 20'd2;
          i_d     = '0;
          ea_d    = HDR_BYTES;
          ph_d    = 2'd0;
          state_d = S_END;
        end
      end

      S_PCALC: begin
        p_d     = p_q + ADDR_W'({diff_q, 1'b0});
        state_d = S_PCHK;
      end

      S_PCHK: begin
        ph_d = 2'd0;
        if (p_q + 20'd2 > lim_w) begin
          res_d   = '{glyph: '0, status: ST_FMT};
          state_d = S_DONE;
        end else begin
          state_d = S_FETCH;
        end
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== hdl/cmap_format4_glyph_lookup.sv =====
// Channel   Dir  Beat contents
// in_i      in   opcode, byte_index, byte_value, codepoint
// out_o     out  glyph_index, status (one beat per lookup, none per write)
// cfg       in   cfg_we_i / cfg_wdata_i: table_bytes
//
// A write beat is stored at the edge it is accepted.
// A lookup runs the header checks, walks past the segments that do not match,
// then reads the delta, range offset and, if needed, a glyph word for the
// matching one or finds that none matches, and hands the result to the output register.
// The memory has one byte read port, so each 16-bit word is read one byte at a time.
// in_i is ready only while no lookup is in flight; a finished result waits in
// the output register, so a stalled out_o lets one more lookup finish and then
// holds in_i.
// Reset clears control state and sets table_bytes to 16; memory contents are
// undefined until written. Top level; depends on cmap4_pkg, the two channel
// interfaces, cmap4_mem and cmap4_walk.
`default_nettype none

module cmap_format4_glyph_lookup import cmap4_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 8192
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  cmap4_in_if.sink             in_i,
  cmap4_out_if.source          out_o,
  input  wire logic            cfg_we_i,
  input  wire logic [TB_W-1:0] cfg_wdata_i
);

  localparam int unsigned AddrBits = $clog2(TABLE_DEPTH);

  logic [TB_W-1:0]     table_bytes_q;
  logic                out_valid_q;
  res_t                out_res_q;

  logic                walk_idle;
  logic                in_fire;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr_full;
  logic [AddrBits-1:0] raddr;
  logic [7:0]          rdata;
  logic                res_valid;
  logic                res_ready;
  res_t                res;

  assign in_i.ready   = walk_idle;
  assign in_fire      = in_i.valid && in_i.ready;
  assign wr_addr_full = ADDR_W'(in_i.byte_index);
  assign wr_en        = in_fire && (in_i.opcode == OP_WRITE) &&
                        (32'(in_i.byte_index) < TABLE_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_bytes_q <= BOUND_MIN;
    end else if (cfg_we_i) begin
      table_bytes_q <= cfg_wdata_i;
    end
  end

  cmap4_mem #(
    .DEPTH     (TABLE_DEPTH),
    .ADDR_BITS (AddrBits)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr_full[AddrBits-1:0]),
    .wdata_i (in_i.byte_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cmap4_walk #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_BITS   (AddrBits)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .table_bytes_i (table_bytes_q),
    .start_i       (in_fire && (in_i.opcode == OP_LOOKUP)),
    .cp_i          (in_i.codepoint),
    .idle_o        (walk_idle),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  // Output register: loads when empty or when its beat is taken this cycle.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.glyph_index = out_res_q.glyph;
  assign out_o.status      = out_res_q.status;

endmodule

`default_nettype wire
